### hdl/bate_pkg.sv
// Package with shared types and constants for the bounded array table engine.
`default_nettype none
package bate_pkg;
	localparam int CAPACITY_DEF = 64;
	localparam int WORD_WIDTH_DEF = 32;
	localparam int REQ_W = 3;
	localparam int POS_W = 6;
	localparam int VAL_W = 32;
	localparam int STAT_W = 2;
	localparam int CNT_W = 7;

	typedef enum logic [REQ_W-1:0] {
		REQ_APPEND = 3'd0,
		REQ_READ = 3'd1,
		REQ_REMOVE_AT = 3'd2,
		REQ_REMOVE_MATCH = 3'd3,
		REQ_REVERSE = 3'd4,
		REQ_SORT = 3'd5,
		REQ_SEARCH = 3'd6,
		REQ_NONE = 3'd7
	} req_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DISPATCH,
		S_RD_WAIT,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_MATCH_RD,
		S_MATCH_CMP,
		S_REV_RDA,
		S_REV_RDB,
		S_REV_WR,
		S_REV_WRB,
		S_SORT_KEY,
		S_SORT_RD,
		S_SORT_CMP,
		S_SORT_PUT,
		S_SRCH_RD,
		S_SRCH_CMP,
		S_SRCH_CHK,
		S_DONE
	} state_t;

	typedef struct packed {
		logic lt;
		logic eq;
	} cmp_t;
endpackage
`default_nettype wire

### hdl/bounded_array_table_engine.sv
// Top level of the bounded array table engine with its request sequencer.
// Each request works through the single memory port: append writes one word, read fetches one word,
// remove at moves each later word down one place, reverse swaps pairs from both ends, search halves
// the range (binary search), remove match compares words in turn and then moves, sort inserts words.
// Work is serialised on the single memory port and comparator; s_tready stays low until the result word is taken.
// Reset clears the word count and the sequencer; memory contents stay undefined.
`default_nettype none
module bounded_array_table_engine #(
	parameter int CAPACITY = bate_pkg::CAPACITY_DEF,
	parameter int WORD_WIDTH = bate_pkg::WORD_WIDTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	// req_type[2:0], position[8:3], operand_value[40:9], zeros[47:41]
	input wire logic [47:0] s_tdata,
	output logic m_tvalid,
	input wire logic m_tready,
	// status[1:0], read_value[33:2], found_position[39:34], element_count[46:40], zero[47]
	output logic [47:0] m_tdata
);
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = CW + 1;

	bate_pkg::state_t state_q, state_d;
	bate_pkg::req_t req_q;
	logic [bate_pkg::POS_W-1:0] pos_q;
	logic [WORD_WIDTH-1:0] val_q, key_q, tmp_q;
	logic [CW-1:0] cnt_q;
	logic [IW-1:0] i_q, j_q, lo_q, hi_q;
	bate_pkg::status_t stat_q;
	logic [bate_pkg::VAL_W-1:0] rd_q;
	logic [bate_pkg::POS_W-1:0] fpos_q;

	logic we;
	logic [AW-1:0] addr;
	logic [WORD_WIDTH-1:0] wdata, rdata;
	bate_pkg::cmp_t cmp;
	logic [WORD_WIDTH-1:0] cmp_a, cmp_b;
	logic [IW-1:0] cnt_x, mid;
	logic [bate_pkg::VAL_W-1:0] rd_ext;

	bate_store #(.CAPACITY(CAPACITY), .WORD_WIDTH(WORD_WIDTH)) u_store (
		.clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
	);

	bate_cmp #(.WORD_WIDTH(WORD_WIDTH)) u_cmp (.a(cmp_a), .b(cmp_b), .res(cmp));

	assign cnt_x = IW'(cnt_q);
	assign mid = IW'((lo_q + hi_q) >> 1);
	assign s_tready = (state_q == bate_pkg::S_IDLE);
	assign m_tvalid = (state_q == bate_pkg::S_DONE);
	assign m_tdata = {1'b0, bate_pkg::CNT_W'(cnt_q), fpos_q, rd_q, stat_q};

	if (WORD_WIDTH >= bate_pkg::VAL_W) begin : g_rd_cut
		assign rd_ext = rdata[bate_pkg::VAL_W-1:0];
	end else begin : g_rd_ext
		assign rd_ext = bate_pkg::VAL_W'($signed(rdata));
	end

	// Comparator operands: sort compares held key to walked word, others read word to operand.
	always_comb begin
		cmp_a = rdata;
		cmp_b = val_q;
		if (state_q == bate_pkg::S_SORT_CMP) begin
			cmp_a = key_q;
			cmp_b = rdata;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bate_pkg::S_IDLE: if (s_tvalid) state_d = bate_pkg::S_DISPATCH;
			bate_pkg::S_DISPATCH: begin
				unique case (req_q)
					bate_pkg::REQ_APPEND: state_d = bate_pkg::S_DONE;
					bate_pkg::REQ_READ: state_d = (IW'(pos_q) >= cnt_x) ?
						bate_pkg::S_DONE : bate_pkg::S_RD_WAIT;
					bate_pkg::REQ_REMOVE_AT: state_d = (IW'(pos_q) >= cnt_x) ?
						bate_pkg::S_DONE : bate_pkg::S_SHIFT_RD;
					bate_pkg::REQ_REMOVE_MATCH: state_d = bate_pkg::S_MATCH_RD;
					bate_pkg::REQ_REVERSE: state_d = bate_pkg::S_REV_RDA;
					bate_pkg::REQ_SORT: state_d = bate_pkg::S_SORT_KEY;
					bate_pkg::REQ_SEARCH: state_d = bate_pkg::S_SRCH_RD;
					default: state_d = bate_pkg::S_DONE;
				endcase
			end
			bate_pkg::S_RD_WAIT: state_d = bate_pkg::S_DONE;
			bate_pkg::S_SHIFT_RD: state_d = (i_q + 1'b1 < cnt_x) ?
				bate_pkg::S_SHIFT_WR : bate_pkg::S_DONE;
			bate_pkg::S_SHIFT_WR: state_d = bate_pkg::S_SHIFT_RD;
			bate_pkg::S_MATCH_RD: state_d = (i_q < cnt_x) ?
				bate_pkg::S_MATCH_CMP : bate_pkg::S_DONE;
			bate_pkg::S_MATCH_CMP: state_d = cmp.eq ?
				bate_pkg::S_SHIFT_RD : bate_pkg::S_MATCH_RD;
			bate_pkg::S_REV_RDA: state_d = (i_q < j_q && j_q < cnt_x) ?
				bate_pkg::S_REV_RDB : bate_pkg::S_DONE;
			bate_pkg::S_REV_RDB: state_d = bate_pkg::S_REV_WR;
			bate_pkg::S_REV_WR: state_d = bate_pkg::S_REV_WRB;
			bate_pkg::S_REV_WRB: state_d = bate_pkg::S_REV_RDA;
			bate_pkg::S_SORT_KEY: state_d = (i_q < cnt_x) ?
				bate_pkg::S_SORT_RD : bate_pkg::S_DONE;
			bate_pkg::S_SORT_RD: state_d = bate_pkg::S_SORT_CMP;
			bate_pkg::S_SORT_CMP: state_d = (cmp.lt && j_q != IW'(1)) ?
				bate_pkg::S_SORT_RD : bate_pkg::S_SORT_PUT;
			bate_pkg::S_SORT_PUT: state_d = bate_pkg::S_SORT_KEY;
			bate_pkg::S_SRCH_RD: state_d = (lo_q < hi_q) ?
				bate_pkg::S_SRCH_CMP : bate_pkg::S_SRCH_CHK;
			bate_pkg::S_SRCH_CMP: state_d = bate_pkg::S_SRCH_RD;
			bate_pkg::S_SRCH_CHK: state_d = bate_pkg::S_DONE;
			bate_pkg::S_DONE: if (m_tready) state_d = bate_pkg::S_IDLE;
			default: state_d = bate_pkg::S_IDLE;
		endcase
	end

	// Memory port control. Reads issued here return data in the following cycle.
	always_comb begin
		we = 1'b0;
		addr = '0;
		wdata = tmp_q;
		unique case (state_q)
			bate_pkg::S_DISPATCH: begin
				addr = (req_q == bate_pkg::REQ_APPEND) ? AW'(cnt_q) : AW'(pos_q);
				wdata = val_q;
				we = (req_q == bate_pkg::REQ_APPEND) && (cnt_x < IW'(CAPACITY));
				if (req_q == bate_pkg::REQ_REMOVE_AT) addr = AW'(pos_q + 1'b1);
				if (req_q == bate_pkg::REQ_SORT) addr = AW'(1);
				if (req_q == bate_pkg::REQ_REVERSE || req_q == bate_pkg::REQ_REMOVE_MATCH)
					addr = '0;
			end
			bate_pkg::S_SHIFT_RD: addr = AW'(i_q + 1'b1);
			bate_pkg::S_SHIFT_WR: begin
				we = 1'b1;
				addr = AW'(i_q);
				wdata = rdata;
			end
			bate_pkg::S_MATCH_RD: addr = AW'(i_q);
			bate_pkg::S_MATCH_CMP: addr = AW'(i_q + 1'b1);
			bate_pkg::S_REV_RDA: addr = AW'(i_q);
			bate_pkg::S_REV_RDB: addr = AW'(j_q);
			bate_pkg::S_REV_WR: begin
				we = 1'b1;
				addr = AW'(i_q);
				wdata = rdata;
			end
			bate_pkg::S_REV_WRB: begin
				we = 1'b1;
				addr = AW'(j_q);
				wdata = tmp_q;
			end
			bate_pkg::S_SORT_KEY: addr = AW'(i_q);
			bate_pkg::S_SORT_RD: addr = AW'(j_q - 1'b1);
			bate_pkg::S_SORT_CMP: begin
				we = cmp.lt;
				addr = AW'(j_q);
				wdata = rdata;
			end
			bate_pkg::S_SORT_PUT: begin
				we = 1'b1;
				addr = AW'(j_q);
				wdata = key_q;
			end
			bate_pkg::S_SRCH_RD: addr = AW'(mid);
			default: addr = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bate_pkg::S_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == bate_pkg::S_DISPATCH && req_q == bate_pkg::REQ_APPEND &&
				cnt_x < IW'(CAPACITY)) cnt_q <= cnt_q + 1'b1;
			if (state_q == bate_pkg::S_SHIFT_RD && !(i_q + 1'b1 < cnt_x))
				cnt_q <= cnt_q - 1'b1;
		end
	end

	// tmp_q holds the lower word of a reverse swap; key_q holds the word that sort inserts.
	always_ff @(posedge clk) begin
		unique case (state_q)
			bate_pkg::S_IDLE: if (s_tvalid) begin
				req_q <= bate_pkg::req_t'(s_tdata[2:0]);
				pos_q <= s_tdata[8:3];
				val_q <= WORD_WIDTH'($signed(s_tdata[40:9]));
				stat_q <= bate_pkg::ST_OK;
				rd_q <= '0;
				fpos_q <= '0;
			end
			bate_pkg::S_DISPATCH: begin
				i_q <= (req_q == bate_pkg::REQ_SORT) ? IW'(1) :
					(req_q == bate_pkg::REQ_REMOVE_AT) ? IW'(pos_q) : '0;
				j_q <= cnt_x - 1'b1;
				lo_q <= '0;
				hi_q <= cnt_x;
				if (req_q == bate_pkg::REQ_APPEND && !(cnt_x < IW'(CAPACITY)))
					stat_q <= bate_pkg::ST_FULL;
				if ((req_q == bate_pkg::REQ_READ || req_q == bate_pkg::REQ_REMOVE_AT) &&
					IW'(pos_q) >= cnt_x) stat_q <= bate_pkg::ST_RANGE;
				if (req_q == bate_pkg::REQ_REMOVE_MATCH) stat_q <= bate_pkg::ST_NOT_FOUND;
			end
			bate_pkg::S_RD_WAIT: rd_q <= rd_ext;
			bate_pkg::S_SHIFT_WR: i_q <= i_q + 1'b1;
			bate_pkg::S_MATCH_CMP: begin
				if (cmp.eq) stat_q <= bate_pkg::ST_OK;
				else i_q <= i_q + 1'b1;
			end
			bate_pkg::S_REV_RDB: tmp_q <= rdata;
			bate_pkg::S_REV_WRB: begin
				i_q <= i_q + 1'b1;
				j_q <= j_q - 1'b1;
			end
			bate_pkg::S_SORT_KEY: begin
				j_q <= i_q;
			end
			bate_pkg::S_SORT_RD: begin
				if (j_q == i_q) key_q <= rdata;
			end
			bate_pkg::S_SORT_CMP: begin
				if (cmp.lt) j_q <= j_q - 1'b1;
			end
			bate_pkg::S_SORT_PUT: i_q <= i_q + 1'b1;
			bate_pkg::S_SRCH_CMP: begin
				if (cmp.lt) lo_q <= mid + 1'b1;
				else hi_q <= mid;
			end
			bate_pkg::S_SRCH_CHK: begin
				if (lo_q < cnt_x && cmp.eq) fpos_q <= bate_pkg::POS_W'(lo_q);
				else stat_q <= bate_pkg::ST_NOT_FOUND;
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_x <= IW'(CAPACITY)) else $error("count above capacity");
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid)) else $error("ready while result pending");
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");
`endif
endmodule
`default_nettype wire

### hdl/bate_store.sv
// Single-port word memory with registered read data.
`default_nettype none
module bate_store #(
	parameter int CAPACITY = bate_pkg::CAPACITY_DEF,
	parameter int WORD_WIDTH = bate_pkg::WORD_WIDTH_DEF,
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [AW-1:0] addr,
	input wire logic [WORD_WIDTH-1:0] wdata,
	output logic [WORD_WIDTH-1:0] rdata
);
	logic [WORD_WIDTH-1:0] mem_q [CAPACITY];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

### hdl/bate_cmp.sv
// Shared signed word comparator.
`default_nettype none
module bate_cmp #(
	parameter int WORD_WIDTH = bate_pkg::WORD_WIDTH_DEF
) (
	input wire logic [WORD_WIDTH-1:0] a,
	input wire logic [WORD_WIDTH-1:0] b,
	output bate_pkg::cmp_t res
);
	always_comb begin
		res.lt = $signed(a) < $signed(b);
		res.eq = (a == b);
	end
endmodule
`default_nettype wire
